// ===== src/mgr_pkg.sv =====
// ----------------------------------------------------------------------------
// mgr_pkg
// Types and constants shared by the multicast group replicator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mgr_pkg;

  localparam int GroupCountDef   = 16;
  localparam int MapsPerGroupDef = 8;

  localparam logic [1:0] KIND_PKT = 2'd0;
  localparam logic [1:0] KIND_GRP = 2'd1;
  localparam logic [1:0] KIND_MAP = 2'd2;

  localparam logic [1:0] ACT_FWD  = 2'd0;
  localparam logic [1:0] ACT_DROP = 2'd1;
  localparam logic [1:0] ACT_COPY = 2'd2;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IP4  = 16'h0800;
  localparam logic [15:0] TYPE_IP6  = 16'h86DD;
  localparam logic [15:0] TCI_KEEP  = 16'hF000;
  localparam logic [15:0] ID_MASK   = 16'h0FFF;

  localparam int MODE_VALID = 0;
  localparam int MODE_SSM   = 1;
  localparam int MODE_IP6   = 2;
  localparam int MAC_MCAST  = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    logic [2:0]  mapping_index;
    logic [15:0] port_id;
    logic [23:0] domain_id;
    logic [47:0] dst_mac;
    logic [15:0] outer_type;
    logic [15:0] inner_type;
    logic [15:0] vlan_tci;
    logic [63:0] src_ip_high;
    logic [63:0] src_ip_low;
    logic [2:0]  flags;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] egress_port;
    logic [15:0] out_tci;
    logic        group_hit;
    logic [3:0]  hit_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [23:0] domain;
    logic [47:0] mac;
    logic [63:0] src_high;
    logic [63:0] src_low;
  } grp_entry_t;

  typedef struct packed {
    logic [15:0] port;
    logic [11:0] domain;
  } map_entry_t;

  typedef struct packed {
    logic        v4;
    logic        v6;
    logic [23:0] domain;
    logic [47:0] mac;
    logic [63:0] src_high;
    logic [63:0] src_low;
  } pkt_key_t;

endpackage

// ===== src/mgr_ram.sv =====
// ----------------------------------------------------------------------------
// mgr_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/mgr_match.sv =====
// ----------------------------------------------------------------------------
// mgr_match
// Compare unit: checks one group entry against the packet lookup key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgr_match
  import mgr_pkg::*;
(
  input  pkt_key_t   key_i,
  input  grp_entry_t ent_i,
  output logic       hit_o
);

  logic base_ok;
  logic src_ok;

  always_comb begin
    base_ok = ent_i.mode[MODE_VALID] && (ent_i.domain == key_i.domain) &&
              (ent_i.mac == key_i.mac);
    src_ok  = 1'b1;
    if (ent_i.mode[MODE_SSM]) begin
      if (key_i.v4) begin
        src_ok = !ent_i.mode[MODE_IP6] && (ent_i.src_low[31:0] == key_i.src_low[31:0]);
      end else begin
        src_ok = ent_i.mode[MODE_IP6] && (ent_i.src_high == key_i.src_high) &&
                 (ent_i.src_low == key_i.src_low);
      end
    end
    hit_o = base_ok && src_ok;
  end

endmodule

// ===== src/l2_multicast_group_replicator_unit.sv =====
// ----------------------------------------------------------------------------
// l2_multicast_group_replicator_unit
// Multicast group lookup and per-group copy generation for L2 packet headers.
// ----------------------------------------------------------------------------
// A packet that is not IP multicast goes straight to the closing state for
// its single result. Other packets scan the group RAM through the shared
// compare unit, one entry per cycle behind the registered read, stopping at
// the first hit; on a hit the unit walks the group's mapping slots through
// the mapping RAM read port, each slot a read state and then a check state
// that can wait on a stalled output, and ends in one closing state. No new
// item is taken while a packet is in work.
`timescale 1ns / 1ps

module l2_multicast_group_replicator_unit
  import mgr_pkg::*;
#(
  parameter int GROUP_COUNT    = GroupCountDef,
  parameter int MAPS_PER_GROUP = MapsPerGroupDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int MapDepth = GROUP_COUNT * MAPS_PER_GROUP;
  localparam int Giw = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int Miw = (MAPS_PER_GROUP > 1) ? $clog2(MAPS_PER_GROUP) : 1;
  localparam int Maw = (MapDepth > 1) ? $clog2(MapDepth) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MRD  = 3'd2;
  localparam logic [2:0] ST_MCHK = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [GROUP_COUNT-1:0] grp_wr_q, grp_wr_d;
  logic [MapDepth-1:0]    map_wr_q, map_wr_d;

  pkt_key_t    key_q, key_d;
  logic        tagged_q, tagged_d;
  logic [15:0] tci_q, tci_d;
  logic [15:0] in_port_q, in_port_d;
  logic [1:0]  fail_act_q, fail_act_d;

  logic [Giw:0]   scan_cnt_q, scan_cnt_d;
  logic           rd_vld_q, rd_vld_d;
  logic [Giw-1:0] rd_idx_q, rd_idx_d;
  logic           hit_q, hit_d;
  logic [Giw-1:0] hit_idx_q, hit_idx_d;
  logic [Miw-1:0] slot_q, slot_d;
  logic           map_ok_q, map_ok_d;

  logic      pend_vld_q, pend_vld_d;
  out_item_t pend_q, pend_d;
  logic      out_vld_q, out_vld_d;
  out_item_t out_q, out_d;

  logic       accept;
  logic       can_push;
  logic       push_en;
  out_item_t  push_item;
  logic       grp_we, map_we;
  logic [Giw-1:0] grp_waddr;
  logic [Maw-1:0] map_waddr, map_raddr;
  logic       grp_re, map_re;
  grp_entry_t grp_wdata, grp_rdata;
  map_entry_t map_wdata, map_rdata;
  logic       grp_hit;
  logic       hdr_tagged;
  logic [15:0] hdr_type;
  logic       hdr_v4, hdr_v6;
  logic [15:0] cur_port;
  logic       copy;
  out_item_t  copy_item;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign can_push    = !out_vld_q || !out_stall_i;

  assign hdr_tagged = (in_item_i.outer_type == TYPE_VLAN);
  assign hdr_type   = hdr_tagged ? in_item_i.inner_type : in_item_i.outer_type;
  assign hdr_v4     = (hdr_type == TYPE_IP4);
  assign hdr_v6     = (hdr_type == TYPE_IP6);

  assign grp_we    = accept && (in_item_i.kind == KIND_GRP) &&
                     (32'(in_item_i.entry_index) < GROUP_COUNT);
  assign grp_waddr = Giw'(32'(in_item_i.entry_index));
  assign grp_wdata = '{mode: in_item_i.flags, domain: in_item_i.domain_id,
                       mac: in_item_i.dst_mac, src_high: in_item_i.src_ip_high,
                       src_low: in_item_i.src_ip_low};
  assign map_we    = accept && (in_item_i.kind == KIND_MAP) &&
                     (32'(in_item_i.entry_index) < GROUP_COUNT) &&
                     (32'(in_item_i.mapping_index) < MAPS_PER_GROUP);
  assign map_waddr = Maw'(32'(in_item_i.entry_index) * MAPS_PER_GROUP +
                          32'(in_item_i.mapping_index));
  assign map_wdata = '{port: in_item_i.port_id, domain: in_item_i.domain_id[11:0]};

  assign grp_re    = (state_q == ST_SCAN) && (32'(scan_cnt_q) < GROUP_COUNT);
  assign map_re    = (state_q == ST_MRD);
  assign map_raddr = Maw'(32'(hit_idx_q) * MAPS_PER_GROUP + 32'(slot_q));

  mgr_ram #(
    .Width($bits(grp_entry_t)),
    .Depth(GROUP_COUNT)
  ) u_grp_ram (
    .clk_i  (clk_i),
    .we_i   (grp_we),
    .waddr_i(grp_waddr),
    .wdata_i(grp_wdata),
    .re_i   (grp_re),
    .raddr_i(scan_cnt_q[Giw-1:0]),
    .rdata_o(grp_rdata)
  );

  mgr_ram #(
    .Width($bits(map_entry_t)),
    .Depth(MapDepth)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .re_i   (map_re),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  mgr_match u_match (
    .key_i(key_q),
    .ent_i(grp_rdata),
    .hit_o(grp_hit)
  );

  assign cur_port = map_ok_q ? map_rdata.port : 16'd0;
  assign copy     = (cur_port != 16'd0) && (cur_port != in_port_q);

  always_comb begin
    copy_item             = '0;
    copy_item.action      = ACT_COPY;
    copy_item.egress_port = cur_port;
    copy_item.out_tci     = tagged_q ? ((tci_q & TCI_KEEP) | (16'(map_rdata.domain) & ID_MASK))
                                     : tci_q;
    copy_item.group_hit   = 1'b1;
    copy_item.hit_index   = 4'(32'(hit_idx_q));
    copy_item.last        = 1'b0;
  end

  always_comb begin
    state_d    = state_q;
    grp_wr_d   = grp_wr_q;
    map_wr_d   = map_wr_q;
    key_d      = key_q;
    tagged_d   = tagged_q;
    tci_d      = tci_q;
    in_port_d  = in_port_q;
    fail_act_d = fail_act_q;
    scan_cnt_d = scan_cnt_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    slot_d     = slot_q;
    map_ok_d   = map_ok_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    push_en    = 1'b0;
    push_item  = pend_q;

    if (grp_we) begin
      grp_wr_d[grp_waddr] = 1'b1;
    end
    if (map_we) begin
      map_wr_d[map_waddr] = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_item_i.kind == KIND_PKT)) begin
          key_d      = '{v4: hdr_v4, v6: hdr_v6, domain: in_item_i.domain_id,
                         mac: in_item_i.dst_mac, src_high: in_item_i.src_ip_high,
                         src_low: in_item_i.src_ip_low};
          tagged_d   = hdr_tagged;
          tci_d      = in_item_i.vlan_tci;
          in_port_d  = in_item_i.port_id;
          scan_cnt_d = '0;
          hit_d      = 1'b0;
          hit_idx_d  = '0;
          pend_vld_d = 1'b0;
          if ((hdr_v4 || hdr_v6) && in_item_i.dst_mac[MAC_MCAST]) begin
            fail_act_d = in_item_i.flags[0] ? ACT_DROP : ACT_FWD;
            state_d    = ST_SCAN;
          end else begin
            fail_act_d = ACT_FWD;
            state_d    = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (grp_re) begin
          scan_cnt_d = scan_cnt_q + 1'b1;
          rd_vld_d   = 1'b1;
          rd_idx_d   = scan_cnt_q[Giw-1:0];
        end
        if (rd_vld_q) begin
          if (grp_wr_q[rd_idx_q] && grp_hit) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            slot_d    = '0;
            rd_vld_d  = 1'b0;
            state_d   = ST_MRD;
          end else if (rd_idx_q == Giw'(GROUP_COUNT - 1)) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_MRD: begin
        map_ok_d = map_wr_q[map_raddr];
        state_d  = ST_MCHK;
      end
      ST_MCHK: begin
        if (copy && pend_vld_q && !can_push) begin
          state_d = ST_MCHK;
        end else begin
          if (copy) begin
            if (pend_vld_q) begin
              push_en   = 1'b1;
              push_item = pend_q;
            end
            pend_vld_d = 1'b1;
            pend_d     = copy_item;
          end
          if (slot_q == Miw'(MAPS_PER_GROUP - 1)) begin
            state_d = ST_FIN;
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = ST_MRD;
          end
        end
      end
      ST_FIN: begin
        if (pend_vld_q) begin
          push_item      = pend_q;
          push_item.last = 1'b1;
        end else begin
          push_item.action      = fail_act_q;
          push_item.egress_port = '0;
          push_item.out_tci     = tci_q;
          push_item.group_hit   = hit_q;
          push_item.hit_index   = 4'(32'(hit_idx_q));
          push_item.last        = 1'b1;
        end
        if (can_push) begin
          push_en    = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (push_en) begin
      out_vld_d = 1'b1;
      out_d     = push_item;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      grp_wr_q   <= '0;
      map_wr_q   <= '0;
      rd_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      grp_wr_q   <= grp_wr_d;
      map_wr_q   <= map_wr_d;
      rd_vld_q   <= rd_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    tagged_q   <= tagged_d;
    tci_q      <= tci_d;
    in_port_q  <= in_port_d;
    fail_act_q <= fail_act_d;
    scan_cnt_q <= scan_cnt_d;
    rd_idx_q   <= rd_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    slot_q     <= slot_d;
    map_ok_q   <= map_ok_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

`ifndef SYNTHESIS
  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MCHK && copy && pend_vld_q && !can_push) |=> (state_q == ST_MCHK))
    else $error("pending copy not held while output stalled");

  a_hit_to_maps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && rd_vld_q && grp_wr_q[rd_idx_q] && grp_hit)
      |=> (state_q == ST_MRD && hit_q))
    else $error("group hit did not start mapping walk");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |-> (push_item.last == (state_q == ST_FIN)))
    else $error("last flag out of place");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |-> can_push)
    else $error("result pushed over a stalled item");
`endif

endmodule
